// ===== rtl/asrenv_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// asrenv_pkg
// Shared types, codes and reset values for the ASR envelope generator.
// ----------------------------------------------------------------------------
package asrenv_pkg;

	localparam int VALUE_BITS_DEFAULT = 24;

	// Configuration port geometry: five 32-bit registers at byte addresses 4*i.
	localparam int ADDR_BITS = 5;
	localparam int DATA_BITS = 32;

	localparam logic [2:0] REG_THRESHOLD    = 3'd0;
	localparam logic [2:0] REG_SUSTAIN      = 3'd1;
	localparam logic [2:0] REG_ATTACK_STEP  = 3'd2;
	localparam logic [2:0] REG_RELEASE_STEP = 3'd3;
	localparam logic [2:0] REG_ONE_SHOT     = 3'd4;

	// Reset values at full width; the top level keeps the low bits it needs.
	localparam logic [31:0] THRESHOLD_RESET = 32'd4194304;
	localparam logic [31:0] SUSTAIN_RESET   = 32'd8388607;
	localparam logic [31:0] STEP_RESET      = 32'd190217;

	// Phase codes as they appear on the result channel.
	localparam logic [1:0] PH_CODE_IDLE    = 2'd0;
	localparam logic [1:0] PH_CODE_ATTACK  = 2'd1;
	localparam logic [1:0] PH_CODE_SUSTAIN = 2'd2;
	localparam logic [1:0] PH_CODE_RELEASE = 2'd3;

	typedef enum logic [3:0] {
		PHASE_IDLE    = 4'b0001,
		PHASE_ATTACK  = 4'b0010,
		PHASE_SUSTAIN = 4'b0100,
		PHASE_RELEASE = 4'b1000
	} phase_t;

	typedef struct packed {
		phase_t phase;
		logic   fresh;
		logic   done;
	} ctrl_t;

	function automatic logic [1:0] phase_code(input phase_t ph);
		logic [1:0] code;
		unique case (ph)
			PHASE_IDLE:    code = PH_CODE_IDLE;
			PHASE_ATTACK:  code = PH_CODE_ATTACK;
			PHASE_SUSTAIN: code = PH_CODE_SUSTAIN;
			PHASE_RELEASE: code = PH_CODE_RELEASE;
			default:       code = PH_CODE_IDLE;
		endcase
		return code;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/asrenv_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// asrenv_step
// One sample of envelope update: edge detection, phase change and clamped step.
// ----------------------------------------------------------------------------
module asrenv_step #(
	parameter int VALUE_BITS = asrenv_pkg::VALUE_BITS_DEFAULT
) (
	input  wire logic [VALUE_BITS-1:0] sample,
	input  wire logic [VALUE_BITS-1:0] prev,
	input  wire logic [VALUE_BITS-1:0] threshold,
	input  wire logic [VALUE_BITS-2:0] hold_level,
	input  wire logic [VALUE_BITS-2:0] attack_step,
	input  wire logic [VALUE_BITS-2:0] release_step,
	input  wire logic                  one_shot,
	input  wire logic [VALUE_BITS-2:0] level,
	input  wire asrenv_pkg::ctrl_t     ctrl,
	output logic      [VALUE_BITS-1:0] prev_next,
	output logic      [VALUE_BITS-2:0] level_next,
	output asrenv_pkg::ctrl_t          ctrl_next,
	output logic      [VALUE_BITS-2:0] envelope,
	output logic      [1:0]            phase_now,
	output logic                       finished
);

	localparam int LEVEL_BITS = VALUE_BITS - 1;

	asrenv_pkg::phase_t ph_start;
	asrenv_pkg::phase_t ph_edge;
	logic               cur_hi;
	logic               prev_hi;
	logic [LEVEL_BITS:0] sum;

	assign cur_hi  = $signed(sample) >= $signed(threshold);
	assign prev_hi = $signed(prev) >= $signed(threshold);
	assign sum     = {1'b0, level} + {1'b0, attack_step};

	always_comb begin
		ph_start = (ctrl.fresh && one_shot) ? asrenv_pkg::PHASE_ATTACK : ctrl.phase;
		priority if (cur_hi && !prev_hi) begin
			ph_edge = asrenv_pkg::PHASE_ATTACK;
		end else if (!cur_hi && prev_hi) begin
			ph_edge = asrenv_pkg::PHASE_RELEASE;
		end else begin
			ph_edge = ph_start;
		end
	end

	always_comb begin
		ctrl_next  = ctrl;
		level_next = level;
		prev_next  = prev;
		envelope   = '0;
		phase_now  = asrenv_pkg::PH_CODE_IDLE;
		finished   = 1'b1;
		if (!ctrl.done) begin
			ctrl_next.fresh = 1'b0;
			ctrl_next.phase = ph_edge;
			prev_next       = sample;
			unique case (ph_edge)
				asrenv_pkg::PHASE_ATTACK: begin
					if (sum >= {1'b0, hold_level}) begin
						level_next      = hold_level;
						ctrl_next.phase = asrenv_pkg::PHASE_SUSTAIN;
					end else begin
						level_next = sum[LEVEL_BITS-1:0];
					end
				end
				asrenv_pkg::PHASE_SUSTAIN: begin
					level_next = hold_level;
				end
				asrenv_pkg::PHASE_RELEASE: begin
					if (level <= release_step) begin
						level_next      = '0;
						ctrl_next.phase = asrenv_pkg::PHASE_IDLE;
						ctrl_next.done  = one_shot;
					end else begin
						level_next = level - release_step;
					end
				end
				default: begin
					level_next = '0;
				end
			endcase
			envelope  = level_next;
			phase_now = asrenv_pkg::phase_code(ctrl_next.phase);
			finished  = ctrl_next.done;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/asr_envelope_generator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// asr_envelope_generator
// Attack-sustain-release envelope driven by threshold crossings of a trigger.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Payload
//  --------  ---------  --------------------  ---------------------------------
//  input     in         in_valid / in_ready   trigger_sample
//  output    out        out_valid / out_ready envelope, phase_now, finished
//  config    in         APB psel/penable      paddr, pwdata, prdata
//
// Each request passes through the input register and then produces its
// result in the output register, and one request can be taken in every
// cycle while the output side keeps up.
// The envelope state advances once per request, when the input register moves
// into the output register; the compare, add and clamp sit in that one stage.
// A stalled output holds the result and the input register, and a new request
// is refused only when both are full.
// Reset is asynchronous and active low; it restores the register defaults and
// an idle, fresh envelope, with no clearing pass.
// ----------------------------------------------------------------------------
module asr_envelope_generator #(
	parameter int VALUE_BITS = asrenv_pkg::VALUE_BITS_DEFAULT
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Trigger samples
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [VALUE_BITS-1:0]            trigger_sample,
	// Envelope results
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic      [VALUE_BITS-2:0]            envelope,
	output logic      [1:0]                       phase_now,
	output logic                                  finished,
	// Configuration
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [asrenv_pkg::ADDR_BITS-1:0] paddr,
	input  wire logic [asrenv_pkg::DATA_BITS-1:0] pwdata,
	output logic      [asrenv_pkg::DATA_BITS-1:0] prdata,
	output logic                                  pready
);

	localparam int LEVEL_BITS = VALUE_BITS - 1;

	// Configuration registers.
	logic [VALUE_BITS-1:0] threshold_q;
	logic [LEVEL_BITS-1:0] sustain_q;
	logic [LEVEL_BITS-1:0] attack_step_q;
	logic [LEVEL_BITS-1:0] release_step_q;
	logic                  one_shot_q;

	// Envelope state.
	asrenv_pkg::ctrl_t     ctrl_q;
	logic [LEVEL_BITS-1:0] level_q;
	logic [VALUE_BITS-1:0] prev_q;

	// Pipeline registers.
	logic                  valid_s1;
	logic [VALUE_BITS-1:0] sample_s1;
	logic                  valid_s2;
	logic [LEVEL_BITS-1:0] envelope_s2;
	logic [1:0]            phase_s2;
	logic                  finished_s2;

	// Step outputs.
	asrenv_pkg::ctrl_t     ctrl_next;
	logic [LEVEL_BITS-1:0] level_next;
	logic [VALUE_BITS-1:0] prev_next;
	logic [LEVEL_BITS-1:0] env_next;
	logic [1:0]            phase_next;
	logic                  finished_next;

	logic                  cfg_write;
	logic [2:0]            reg_index;
	logic                  advance;

	// ------------------------------------------------------------------------
	// Configuration port. The low two address bits are ignored, and indexes
	// past the last register are read as zero and written to nothing.
	// ------------------------------------------------------------------------
	assign pready    = 1'b1;
	assign reg_index = paddr[asrenv_pkg::ADDR_BITS-1:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q    <= asrenv_pkg::THRESHOLD_RESET[VALUE_BITS-1:0];
			sustain_q      <= asrenv_pkg::SUSTAIN_RESET[LEVEL_BITS-1:0];
			attack_step_q  <= asrenv_pkg::STEP_RESET[LEVEL_BITS-1:0];
			release_step_q <= asrenv_pkg::STEP_RESET[LEVEL_BITS-1:0];
			one_shot_q     <= 1'b0;
		end else if (cfg_write) begin
			unique case (reg_index)
				asrenv_pkg::REG_THRESHOLD:    threshold_q    <= pwdata[VALUE_BITS-1:0];
				asrenv_pkg::REG_SUSTAIN:      sustain_q      <= pwdata[LEVEL_BITS-1:0];
				asrenv_pkg::REG_ATTACK_STEP:  attack_step_q  <= pwdata[LEVEL_BITS-1:0];
				asrenv_pkg::REG_RELEASE_STEP: release_step_q <= pwdata[LEVEL_BITS-1:0];
				asrenv_pkg::REG_ONE_SHOT:     one_shot_q     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_index)
			asrenv_pkg::REG_THRESHOLD:    prdata = asrenv_pkg::DATA_BITS'(threshold_q);
			asrenv_pkg::REG_SUSTAIN:      prdata = asrenv_pkg::DATA_BITS'(sustain_q);
			asrenv_pkg::REG_ATTACK_STEP:  prdata = asrenv_pkg::DATA_BITS'(attack_step_q);
			asrenv_pkg::REG_RELEASE_STEP: prdata = asrenv_pkg::DATA_BITS'(release_step_q);
			asrenv_pkg::REG_ONE_SHOT:     prdata = asrenv_pkg::DATA_BITS'(one_shot_q);
			default:                      prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------------
	// Handshake. The input stage moves on whenever the output register is
	// empty or being emptied in this cycle; the input register then takes
	// a new request in the same cycle.
	// ------------------------------------------------------------------------
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sample_s1 <= trigger_sample;
		end
	end

	// ------------------------------------------------------------------------
	// Envelope update for the request in the input register.
	// ------------------------------------------------------------------------
	asrenv_step #(
		.VALUE_BITS(VALUE_BITS)
	) u_step (
		.sample       (sample_s1),
		.prev         (prev_q),
		.threshold    (threshold_q),
		.hold_level   (sustain_q),
		.attack_step  (attack_step_q),
		.release_step (release_step_q),
		.one_shot     (one_shot_q),
		.level        (level_q),
		.ctrl         (ctrl_q),
		.prev_next    (prev_next),
		.level_next   (level_next),
		.ctrl_next    (ctrl_next),
		.envelope     (env_next),
		.phase_now    (phase_next),
		.finished     (finished_next)
	);

	// The envelope state is control state and comes up idle and fresh, so a
	// one-shot setting written before the first sample still starts attack.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q  <= '{phase: asrenv_pkg::PHASE_IDLE, fresh: 1'b1, done: 1'b0};
			level_q <= '0;
			prev_q  <= '0;
		end else if (advance) begin
			ctrl_q  <= ctrl_next;
			level_q <= level_next;
			prev_q  <= prev_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			envelope_s2 <= env_next;
			phase_s2    <= phase_next;
			finished_s2 <= finished_next;
		end
	end

	assign out_valid = valid_s2;
	assign envelope  = envelope_s2;
	assign phase_now = phase_s2;
	assign finished  = finished_s2;

`ifndef ASSERT_OFF
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_q.done |=> ctrl_q.done)
		else $error("finished flag cleared without reset");

	a_fresh_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> !ctrl_q.fresh)
		else $error("fresh flag survived a sample");

	a_finished_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && finished_s2) |-> (envelope_s2 == '0 &&
		phase_s2 == asrenv_pkg::PH_CODE_IDLE))
		else $error("finished result with non-zero envelope or phase");

	a_refuse_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2 && !out_ready))
		else $error("input refused with room in the pipeline");
`endif

endmodule
`default_nettype wire

// ===== sim/tb_asr_envelope_generator.sv =====
// ----------------------------------------------------------------------------
// tb_asr_envelope_generator
// Self-checking bench for the ASR envelope generator. A behavioural predictor
// tracks phase, level, the previous trigger and the one-shot flags, and every
// result from the block is compared field by field against it. Directed
// requests cover the clamps, crossings and one-shot behaviour; random gate
// bursts under varied settings and random stalls on both channels follow.
// ----------------------------------------------------------------------------
module tb_asr_envelope_generator;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int VB = asrenv_pkg::VALUE_BITS_DEFAULT;
	localparam int LB = VB - 1;
	localparam int TRIG_MAX = (1 << (VB - 1)) - 1;
	localparam int TRIG_MIN = -(1 << (VB - 1));
	localparam int DRAIN_CYCLES = 6;
	localparam int RANDOM_REQUESTS = 470;
	// An address past the last register; writes to it must change nothing.
	localparam logic [2:0] REG_UNMAPPED = 3'd5;

	typedef struct {
		logic [LB-1:0] env;
		logic [1:0]    ph;
		logic          fin;
	} envelope_result_t;

	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_ready;
	logic [VB-1:0]                   trigger_sample;
	logic                            out_valid;
	logic                            out_ready;
	logic [LB-1:0]                   envelope;
	logic [1:0]                      phase_now;
	logic                            finished;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [asrenv_pkg::ADDR_BITS-1:0] paddr;
	logic [asrenv_pkg::DATA_BITS-1:0] pwdata;
	logic [asrenv_pkg::DATA_BITS-1:0] prdata;
	logic                            pready;

	asr_envelope_generator #(
		.VALUE_BITS(VB)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.trigger_sample(trigger_sample),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.envelope      (envelope),
		.phase_now     (phase_now),
		.finished      (finished),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// Settings as the block should hold them, updated on every register write.
	logic signed [VB-1:0] cfg_threshold;
	logic [LB-1:0]        cfg_sustain;
	logic [LB-1:0]        cfg_attack;
	logic [LB-1:0]        cfg_release;
	logic                 cfg_one_shot;

	// Envelope state of the predictor.
	logic [1:0]    env_phase;
	logic [LB-1:0] env_level;
	logic [VB-1:0] env_prev;
	logic          env_fresh;
	logic          env_done;

	envelope_result_t pending_envelopes[$];
	int               mismatch_count;
	int               requests_sent;
	// When set, the matching side runs without any gaps or stalls.
	logic             tx_calm;
	logic             rx_calm;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Works out the result of one trigger sample and advances the state. Once
	// the one-shot envelope has finished, nothing moves until reset.
	function automatic envelope_result_t advance_envelope(input logic [VB-1:0] smp);
		envelope_result_t r;
		logic [LB:0]      sum;
		if (env_done) begin
			r.env = '0;
			r.ph  = asrenv_pkg::PH_CODE_IDLE;
			r.fin = 1'b1;
			return r;
		end
		// The very first sample after reset may open in attack.
		if (env_fresh) begin
			if (cfg_one_shot)
				env_phase = asrenv_pkg::PH_CODE_ATTACK;
			env_fresh = 1'b0;
		end
		if ($signed(smp) >= cfg_threshold && $signed(env_prev) < cfg_threshold)
			env_phase = asrenv_pkg::PH_CODE_ATTACK;
		else if ($signed(smp) < cfg_threshold && $signed(env_prev) >= cfg_threshold)
			env_phase = asrenv_pkg::PH_CODE_RELEASE;
		case (env_phase)
			asrenv_pkg::PH_CODE_ATTACK: begin
				sum = {1'b0, env_level} + {1'b0, cfg_attack};
				// The clamp also catches a sustain level below the current level.
				if (sum >= {1'b0, cfg_sustain}) begin
					env_level = cfg_sustain;
					env_phase = asrenv_pkg::PH_CODE_SUSTAIN;
				end else begin
					env_level = sum[LB-1:0];
				end
			end
			asrenv_pkg::PH_CODE_SUSTAIN: env_level = cfg_sustain;
			asrenv_pkg::PH_CODE_RELEASE: begin
				if (env_level <= cfg_release) begin
					env_level = '0;
					env_phase = asrenv_pkg::PH_CODE_IDLE;
					if (cfg_one_shot)
						env_done = 1'b1;
				end else begin
					env_level = env_level - cfg_release;
				end
			end
			default: env_level = '0;
		endcase
		env_prev = smp;
		r.env = env_level;
		r.ph  = env_phase;
		r.fin = env_done;
		return r;
	endfunction

	// Mostly back-to-back, sometimes a short pause, now and then a long one.
	function automatic int pick_gap();
		int r;
		if (tx_calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Sends one trigger sample and records the result it must produce. The
	// prediction is made at the edge where the request is taken, so it follows
	// the order in which the block sees the requests.
	task automatic send_sample(input logic [VB-1:0] smp);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid       <= 1'b1;
		trigger_sample <= smp;
		do
			@(posedge clk);
		while (!in_ready);
		pending_envelopes.push_back(advance_envelope(smp));
		requests_sent++;
	endtask

	// Lowers the request line and waits until every result has come back, then
	// lets the clock run on for DRAIN_CYCLES so that nothing is left in the pipeline.
	task automatic wait_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_envelopes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One APB write: setup cycle, then access cycle until pready. Only ever
	// called with the block drained.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		// Bits above a register's width are dropped.
		case (idx)
			asrenv_pkg::REG_THRESHOLD:    cfg_threshold = val[VB-1:0];
			asrenv_pkg::REG_SUSTAIN:      cfg_sustain   = val[LB-1:0];
			asrenv_pkg::REG_ATTACK_STEP:  cfg_attack    = val[LB-1:0];
			asrenv_pkg::REG_RELEASE_STEP: cfg_release   = val[LB-1:0];
			asrenv_pkg::REG_ONE_SHOT:     cfg_one_shot  = val[0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// A sample at or above the current threshold.
	function automatic logic [VB-1:0] gate_high();
		int t;
		t = cfg_threshold;
		return VB'(t + int'($urandom_range(0, TRIG_MAX - t)));
	endfunction

	// A sample below the threshold; with the lowest threshold none exists.
	function automatic logic [VB-1:0] gate_low();
		int t;
		t = cfg_threshold;
		if (t == TRIG_MIN)
			return VB'($urandom);
		return VB'(t - 1 - int'($urandom_range(0, t - 1 - TRIG_MIN)));
	endfunction

	// Writing one-shot after reset but before the first sample must put the
	// envelope straight into attack, even though the trigger stays low.
	task automatic test_one_shot_start();
		write_reg(asrenv_pkg::REG_ONE_SHOT, 32'd1);
		send_sample(VB'(TRIG_MIN));
		send_sample(VB'(TRIG_MIN));
		wait_until_drained();
		// Turned off again so that release cannot finish the envelope yet.
		write_reg(asrenv_pkg::REG_ONE_SHOT, 32'd0);
	endtask

	// Walks through the crossings and both clamps with small hand-picked values.
	task automatic test_crossings_and_clamps();
		write_reg(asrenv_pkg::REG_THRESHOLD, 32'd0);
		write_reg(asrenv_pkg::REG_SUSTAIN, 32'd1000);
		write_reg(asrenv_pkg::REG_ATTACK_STEP, 32'd300);
		write_reg(asrenv_pkg::REG_RELEASE_STEP, 32'd400);
		write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
		// The level is already far above sustain, so attack clamps downwards.
		send_sample(VB'(TRIG_MAX));
		send_sample(VB'(5));
		wait_until_drained();
		// Sustain follows the register on every sample.
		write_reg(asrenv_pkg::REG_SUSTAIN, 32'd700);
		send_sample(VB'(5));
		send_sample(VB'(TRIG_MIN));
		// Level 300 against a step of 400: release stops at exactly zero.
		send_sample(VB'(-1));
		send_sample(VB'(-5));
		// A sample equal to the threshold counts as above it.
		send_sample(VB'(0));
		send_sample(VB'(1));
		send_sample(VB'(2));
		wait_until_drained();
		// With no attack step the level holds where it is.
		write_reg(asrenv_pkg::REG_ATTACK_STEP, 32'd0);
		send_sample(VB'(-1));
		send_sample(VB'(-2));
		send_sample(VB'(TRIG_MAX));
		send_sample(VB'(TRIG_MAX));
		wait_until_drained();
		// At the lowest threshold no crossing is possible.
		write_reg(asrenv_pkg::REG_ATTACK_STEP, 32'd300);
		write_reg(asrenv_pkg::REG_THRESHOLD, 32'hFF80_0000);
		send_sample(VB'(TRIG_MIN));
		send_sample(VB'(TRIG_MAX));
		wait_until_drained();
		// At the highest threshold only the largest sample counts as high.
		write_reg(asrenv_pkg::REG_THRESHOLD, TRIG_MAX);
		send_sample(VB'(TRIG_MAX - 1));
		send_sample(VB'(TRIG_MAX));
		wait_until_drained();
	endtask

	// New settings for one random phase, extremes included. Junk above the
	// register widths is left in on purpose.
	task automatic randomize_settings();
		logic [31:0] thr;
		logic [31:0] sus;
		logic [31:0] atk;
		logic [31:0] rel;
		case ($urandom_range(0, 9))
			0: thr = 32'hFF80_0000;
			1: thr = TRIG_MAX;
			2: thr = '0;
			default: thr = $urandom;
		endcase
		case ($urandom_range(0, 9))
			0: sus = '0;
			1: sus = TRIG_MAX;
			default: sus = $urandom_range(1, TRIG_MAX);
		endcase
		// Steps are mostly a fraction of sustain so that gates of a few dozen
		// samples reach the clamps.
		case ($urandom_range(0, 9))
			0: atk = '0;
			1: atk = {9'($urandom_range(0, 511)), 23'(TRIG_MAX)};
			2: atk = $urandom;
			default: atk = sus[LB-1:0] / $urandom_range(1, 16);
		endcase
		case ($urandom_range(0, 9))
			0: rel = '0;
			1: rel = TRIG_MAX;
			2: rel = $urandom_range(1, 1 << $urandom_range(1, 22));
			default: rel = sus[LB-1:0] / $urandom_range(1, 16);
		endcase
		write_reg(asrenv_pkg::REG_THRESHOLD, thr);
		write_reg(asrenv_pkg::REG_SUSTAIN, sus);
		write_reg(asrenv_pkg::REG_ATTACK_STEP, atk);
		write_reg(asrenv_pkg::REG_RELEASE_STEP, rel);
		if ($urandom_range(0, 7) == 0)
			write_reg(REG_UNMAPPED, $urandom);
	endtask

	// Bursts of gate-on and gate-off samples with random content, with a little
	// noise mixed in. Every phase ends drained, so the sender regularly waits
	// for all outstanding results before carrying on.
	task automatic test_random_gates();
		int target;
		int bursts;
		int run;
		target = requests_sent + RANDOM_REQUESTS;
		while (requests_sent < target) begin
			randomize_settings();
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			bursts  = $urandom_range(1, 4);
			repeat (bursts) begin
				run = $urandom_range(1, 24);
				repeat (run)
					send_sample(($urandom_range(0, 9) == 0) ? VB'($urandom) : gate_high());
				run = $urandom_range(1, 24);
				repeat (run)
					send_sample(($urandom_range(0, 9) == 0) ? VB'($urandom) : gate_low());
			end
			wait_until_drained();
		end
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	// A one-shot release that reaches zero finishes the envelope for good; later
	// crossings must leave it at zero and idle.
	task automatic test_one_shot_finish();
		write_reg(asrenv_pkg::REG_THRESHOLD, 32'd0);
		write_reg(asrenv_pkg::REG_RELEASE_STEP, TRIG_MAX);
		write_reg(asrenv_pkg::REG_ONE_SHOT, 32'd1);
		send_sample(VB'(-1));
		send_sample(VB'(TRIG_MAX));
		send_sample(VB'(TRIG_MIN));
		send_sample(VB'(TRIG_MAX));
		send_sample(VB'(TRIG_MIN));
		send_sample(VB'(TRIG_MAX));
		wait_until_drained();
	endtask

	// Compares every result taken from the block with the oldest prediction.
	always @(posedge clk) begin
		envelope_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_envelopes.size() == 0) begin
				$error("result with no request outstanding: envelope %0d phase_now %0d finished %0d",
					envelope, phase_now, finished);
				mismatch_count++;
			end else begin
				want = pending_envelopes.pop_front();
				if (envelope !== want.env) begin
					$error("envelope: expected %0d, got %0d", want.env, envelope);
					mismatch_count++;
				end
				if (phase_now !== want.ph) begin
					$error("phase_now: expected %0d, got %0d", want.ph, phase_now);
					mismatch_count++;
				end
				if (finished !== want.fin) begin
					$error("finished: expected %0d, got %0d", want.fin, finished);
					mismatch_count++;
				end
			end
		end
	end

	// Result side: ready most of the time, short stalls, and the odd long one.
	initial begin
		int   hold;
		int   r;
		logic rdy;
		out_ready = 1'b0;
		forever begin
			if (rx_calm) begin
				rdy  = 1'b1;
				hold = 1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					rdy  = 1'b1;
					hold = $urandom_range(1, 8);
				end else if (r < 95) begin
					rdy  = 1'b0;
					hold = $urandom_range(1, 3);
				end else begin
					rdy  = 1'b0;
					hold = $urandom_range(10, 40);
				end
			end
			repeat (hold) begin
				@(negedge clk);
				out_ready <= rdy;
			end
		end
	end

	// Generous upper bound on the whole run; a hang ends here.
	initial begin
		#2_000_000;
		$display("[asr_envelope_generator] ERROR");
		$finish;
	end

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		trigger_sample = '0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		tx_calm        = 1'b0;
		rx_calm        = 1'b0;
		mismatch_count = 0;
		requests_sent  = 0;
		cfg_threshold  = asrenv_pkg::THRESHOLD_RESET[VB-1:0];
		cfg_sustain    = asrenv_pkg::SUSTAIN_RESET[LB-1:0];
		cfg_attack     = asrenv_pkg::STEP_RESET[LB-1:0];
		cfg_release    = asrenv_pkg::STEP_RESET[LB-1:0];
		cfg_one_shot   = 1'b0;
		env_phase      = asrenv_pkg::PH_CODE_IDLE;
		env_level      = '0;
		env_prev       = '0;
		env_fresh      = 1'b1;
		env_done       = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_one_shot_start();
		test_crossings_and_clamps();
		test_random_gates();
		test_one_shot_finish();

		if (mismatch_count == 0)
			$display("[asr_envelope_generator] OK");
		else
			$display("[asr_envelope_generator] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/asrenv_pkg.sv
rtl/asrenv_step.sv
rtl/asr_envelope_generator.sv
sim/tb_asr_envelope_generator.sv
